@@ design/wprw_pkg.sv @@
// Package: types, constants and divider control structs for the percentile rank window.
package wprw_pkg;

    localparam int HISTORY_DEPTH = 16384;
    localparam int MIN_HISTORY   = 10;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int FILL_W        = ADDR_W + 1;

    localparam int VOL_W    = 32;
    localparam int IMB_W    = 16;
    localparam int LEN_W    = 14;
    localparam int ALPHA_W  = 16;
    localparam int FACTOR_W = ALPHA_W + 1;
    localparam int WEIGHT_W = 24;
    localparam int ACC_W    = ADDR_W + WEIGHT_W;
    localparam int DSUM_W   = ACC_W + 4;
    localparam int DEN_W    = ACC_W + 1;
    localparam int QUO_W    = 16;
    localparam int STEP_W   = $clog2(QUO_W + 1);
    localparam int LVL_STEPS = 3;
    localparam int LEVEL_W  = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << (WEIGHT_W - 1);
    localparam logic [IMB_W-1:0]    IMB_MAX    = {1'b0, {(IMB_W-1){1'b1}}};
    localparam logic [LEN_W-1:0]    LOOKBACK_RESET = LEN_W'(2000);
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET    = ALPHA_W'(3277);

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_COMPUTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_VOLUME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WARMING   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 2'd1;

    typedef struct packed {
        logic [VOL_W-1:0] bid_volume;
        logic [VOL_W-1:0] ask_volume;
    } t_in_item;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic [STATUS_W-1:0]       status;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DEN_W-1:0]  rem0;
        logic [QUO_W-1:0]  low;
        logic [DEN_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ design/wprw_div.sv @@
// Shared restoring divider: one quotient bit per cycle, step count set per request.
module wprw_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wprw_pkg::t_div_req i_req,
    output wprw_pkg::t_div_rsp o_rsp
);
    import wprw_pkg::*;

    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUO_W-1:0]  r_low;
    logic [QUO_W-1:0]  r_quot;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] trial;
    logic           fits;

    // Shift in the next dividend bit and try the subtract
    assign shifted = {r_rem, r_low[QUO_W-1]};
    assign trial   = shifted - {1'b0, r_den};
    assign fits    = (shifted >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= i_req.rem0;
                r_den  <= i_req.den;
                r_low  <= i_req.low;
                r_quot <= '0;
                r_cnt  <= i_req.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
                r_low  <= {r_low[QUO_W-2:0], 1'b0};
                r_quot <= {r_quot[QUO_W-2:0], fits};
                r_cnt  <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

@@ design/weighted_percentile_rank_window_core.sv @@
// Top level: sequencer, history ring and weighted rank walk around the shared divider.
// For a ranked item the block runs 16 divider steps for the imbalance, then walks the history
// one entry per cycle, newest first, then runs 3 divider steps for the level; warming-up items
// stop after the history store, and zero-volume items skip the divider and the ring.
// One item at a time: the next item can be taken in the cycle after its result is loaded.
// Reset: synchronous, active low; clears pointer, fill count and output valid; presets config.
module weighted_percentile_rank_window_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  wprw_pkg::t_in_item                  i_in_data,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output wprw_pkg::t_out_item                 o_out_data,
    input  logic                                i_out_stall,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wprw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wprw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import wprw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_IMB_GO, S_IMB_WAIT, S_STORE, S_CHECK,
        S_WALK, S_DIFF, S_DSUM, S_LVL_GO, S_LVL_WAIT, S_DONE
    } t_state;

    t_state r_state;

    logic [LEN_W-1:0]    r_lookback;
    logic [ALPHA_W-1:0]  r_alpha;
    logic [ADDR_W-1:0]   r_wp;
    logic [FILL_W-1:0]   r_fill;
    logic [VOL_W-1:0]    r_bid;
    logic [VOL_W-1:0]    r_ask;
    logic [VOL_W:0]      r_tot;
    logic [VOL_W-1:0]    r_mag;
    logic                r_ask_ge;
    logic signed [IMB_W-1:0] r_cur;
    logic [FILL_W-1:0]   r_held;
    logic [FILL_W-1:0]   r_issue;
    logic [ADDR_W-1:0]   r_rd_idx;
    logic                r_dv;
    logic [FACTOR_W-1:0] r_factor;
    logic [WEIGHT_W-1:0] r_w;
    logic [ACC_W-1:0]    r_below;
    logic [ACC_W-1:0]    r_total;
    logic [ACC_W-1:0]    r_diff;
    logic                r_neg;
    logic [DSUM_W-1:0]   r_dsum;
    t_out_item           r_res;
    t_out_item           r_out;
    logic                r_out_valid;

    logic [IMB_W-1:0]    mem [HISTORY_DEPTH];
    logic signed [IMB_W-1:0] r_rd_data;

    logic                mem_we;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [WEIGHT_W+FACTOR_W-1:0] n_prod;
    logic [FILL_W-1:0]   n_len;
    logic [FILL_W-1:0]   n_held;
    logic [ACC_W:0]      two_below;
    logic [ACC_W:0]      total_ext;
    logic [QUO_W-1:0]    n_q;
    logic [LEVEL_W-1:0]  lvl_mag;
    logic                out_free;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    wprw_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // Launch the imbalance or the level division
    always_comb begin
        div_req.start = (r_state == S_IMB_GO) || (r_state == S_LVL_GO);
        if (r_state == S_LVL_GO) begin
            div_req.steps = STEP_W'(LVL_STEPS);
            div_req.rem0  = r_dsum[DSUM_W-1:LVL_STEPS];
            div_req.low   = {r_dsum[LVL_STEPS-1:0], {(QUO_W-LVL_STEPS){1'b0}}};
            div_req.den   = {r_total, 1'b0};
        end else begin
            div_req.steps = STEP_W'(QUO_W);
            div_req.rem0  = DEN_W'(r_mag >> 1);
            div_req.low   = {r_mag[0], {(QUO_W-1){1'b0}}};
            div_req.den   = DEN_W'(r_tot);
        end
    end

    // Ring memory port control
    assign mem_we  = (r_state == S_STORE);
    assign rd_en   = (r_state == S_WALK) && (r_issue != r_held);
    assign rd_addr = r_rd_idx - ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= r_cur;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Next weight, window size and rounding helpers
    assign n_prod    = r_w * r_factor;
    assign n_len     = (r_lookback == '0) ? FILL_W'(1) :
                       ((FILL_W'(r_lookback) > FILL_W'(HISTORY_DEPTH)) ?
                        FILL_W'(HISTORY_DEPTH) : FILL_W'(r_lookback));
    assign n_held    = (r_fill < n_len) ? r_fill : n_len;
    assign two_below = {r_below, 1'b0};
    assign total_ext = {1'b0, r_total};
    assign n_q       = div_rsp.quot;
    assign lvl_mag   = {1'b0, n_q[LVL_STEPS-1:0]};
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_lookback  <= LOOKBACK_RESET;
            r_alpha     <= ALPHA_RESET;
            r_out_valid <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LOOKBACK: r_lookback <= i_cfg_data[LEN_W-1:0];
                    CFG_ALPHA:    r_alpha    <= i_cfg_data[ALPHA_W-1:0];
                    default: ;
                endcase
            end

            // Drop the output item once taken, unless the next one is loaded now
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_bid <= i_in_data.bid_volume;
                        r_ask <= i_in_data.ask_volume;
                        if (i_in_data.bid_volume == '0 && i_in_data.ask_volume == '0) begin
                            r_res.level  <= '0;
                            r_res.status <= ST_NO_VOLUME;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_tot    <= {1'b0, r_bid} + {1'b0, r_ask};
                    r_ask_ge <= (r_ask >= r_bid);
                    r_mag    <= (r_ask >= r_bid) ? (r_ask - r_bid) : (r_bid - r_ask);
                    r_state  <= S_IMB_GO;
                end
                S_IMB_GO: begin
                    r_state <= S_IMB_WAIT;
                end
                S_IMB_WAIT: begin
                    // Saturate positive, negate toward zero for bid-heavy items
                    if (div_rsp.done) begin
                        if (r_ask_ge) begin
                            r_cur <= (n_q > IMB_MAX) ? IMB_MAX : n_q;
                        end else begin
                            r_cur <= IMB_W'(0) - n_q;
                        end
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    r_wp <= r_wp + ADDR_W'(1);
                    if (r_fill < FILL_W'(HISTORY_DEPTH)) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_held <= n_held;
                    if (n_held < FILL_W'(MIN_HISTORY)) begin
                        r_res.level  <= '0;
                        r_res.status <= ST_WARMING;
                        r_state      <= S_DONE;
                    end else begin
                        r_rd_idx <= r_wp;
                        r_issue  <= '0;
                        r_dv     <= 1'b0;
                        r_w      <= WEIGHT_ONE;
                        r_factor <= FACTOR_W'(HISTORY_DEPTH * 0 + 65536) - FACTOR_W'(r_alpha);
                        r_below  <= '0;
                        r_total  <= '0;
                        r_state  <= S_WALK;
                    end
                end
                S_WALK: begin
                    // Issue one read per cycle, newest first
                    if (rd_en) begin
                        r_rd_idx <= rd_addr;
                        r_issue  <= r_issue + FILL_W'(1);
                    end
                    r_dv <= rd_en;
                    // Accumulate the entry that came back
                    if (r_dv) begin
                        if (r_rd_data < r_cur) begin
                            r_below <= r_below + ACC_W'(r_w);
                        end
                        r_total <= r_total + ACC_W'(r_w);
                        r_w     <= n_prod[WEIGHT_W+ALPHA_W-1:ALPHA_W];
                    end
                    if (!rd_en && !r_dv) begin
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_neg  <= (two_below < total_ext);
                    r_diff <= (two_below < total_ext) ? ACC_W'(total_ext - two_below)
                                                      : ACC_W'(two_below - total_ext);
                    r_state <= S_DSUM;
                end
                S_DSUM: begin
                    r_dsum  <= DSUM_W'({r_diff, 3'b000}) + DSUM_W'(r_total);
                    r_state <= S_LVL_GO;
                end
                S_LVL_GO: begin
                    r_state <= S_LVL_WAIT;
                end
                S_LVL_WAIT: begin
                    if (div_rsp.done) begin
                        r_res.level  <= r_neg ? (~lvl_mag + LEVEL_W'(1)) : lvl_mag;
                        r_res.status <= ST_COMPUTED;
                        r_state      <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hand the result over once the output register is free
                    if (out_free) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

`ifndef SYNTHESIS
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_IMB_WAIT) || (r_state == S_LVL_WAIT))
        else $error("divider finished outside a wait state");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HISTORY_DEPTH))
        else $error("fill count beyond history depth");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_issue <= r_held) && (r_held >= FILL_W'(MIN_HISTORY)))
        else $error("walk issued past the window");

    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_COMPUTED)) |-> (o_out_data.level == '0))
        else $error("nonzero level on an uncomputed item");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == ST_COMPUTED)) |->
        ((o_out_data.level >= -4) && (o_out_data.level <= 4)))
        else $error("level out of range");
`endif

endmodule

@@ tb/tb_weighted_percentile_rank_window_core.sv @@
// Self-checking testbench for the weighted percentile rank window core.
module tb_weighted_percentile_rank_window_core;
    timeunit 1ns;
    timeprecision 1ps;

    import wprw_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int END_PAUSE   = 64;
    localparam int EXP_DEPTH   = 16;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_data;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Mirror of the block's history ring and registers
    logic signed [IMB_W-1:0] imb_ring [HISTORY_DEPTH];
    int                      ring_wp      = 0;
    int                      ring_fill    = 0;
    logic [LEN_W-1:0]        lookback_reg = LOOKBACK_RESET;
    logic [ALPHA_W-1:0]      alpha_reg    = ALPHA_RESET;

    // Expected results in acceptance order, written and read by running counts
    t_out_item expected_ranks [EXP_DEPTH];
    int        exp_wr = 0;
    int        exp_rd = 0;

    int   mismatch_count = 0;
    int   bars_sent      = 0;
    int   ranks_checked  = 0;
    int   ranked_seen    = 0;
    int   warming_seen   = 0;
    int   no_volume_seen = 0;
    int   settings_used  = 0;
    int   cycle_count    = 0;
    int   out_stall_left = 0;
    logic in_idle_en     = 1'b1;
    logic out_idle_en    = 1'b1;

    weighted_percentile_rank_window_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Push one bar into the mirrored ring and work out its rank level
    function automatic t_out_item predict_rank(t_in_item bar);
        t_out_item res;
        longint    bid, ask, vol_sum, diff, quo;
        longint    factor, weight, below, total, num, mag, rnd;
        int        cur, span, held, idx;
        res.level  = '0;
        res.status = ST_COMPUTED;
        bid     = bar.bid_volume;
        ask     = bar.ask_volume;
        vol_sum = bid + ask;
        if (vol_sum == 0) begin
            res.status = ST_NO_VOLUME;
            return res;
        end
        // Imbalance in Q1.15, truncated toward zero, +1.0 saturates
        diff = (ask >= bid) ? ask - bid : bid - ask;
        quo  = (diff << 15) / vol_sum;
        if (ask >= bid)
            cur = (quo > 32767) ? 32767 : int'(quo);
        else
            cur = -int'(quo);
        imb_ring[ring_wp] = IMB_W'(cur);
        ring_wp = (ring_wp + 1) % HISTORY_DEPTH;
        if (ring_fill < HISTORY_DEPTH)
            ring_fill++;
        // Window size: lookback clamped to 1..depth, limited by fill
        span = (lookback_reg == 0) ? 1 : int'(lookback_reg);
        if (span > HISTORY_DEPTH)
            span = HISTORY_DEPTH;
        held = (ring_fill < span) ? ring_fill : span;
        if (held < MIN_HISTORY) begin
            res.status = ST_WARMING;
            return res;
        end
        // Walk newest to oldest with geometric weights
        factor = 65536 - longint'(alpha_reg);
        weight = longint'(WEIGHT_ONE);
        below  = 0;
        total  = 0;
        idx    = ring_wp;
        for (int k = 0; k < held; k++) begin
            idx = (idx == 0) ? HISTORY_DEPTH - 1 : idx - 1;
            if (int'(imb_ring[idx]) < cur)
                below += weight;
            total += weight;
            weight = (weight * factor) >>> 16;
        end
        // Round (8*below - 4*total)/total, halves away from zero
        num = 8 * below - 4 * total;
        mag = (num < 0) ? -num : num;
        rnd = (2 * mag + total) / (2 * total);
        res.level = LEVEL_W'((num < 0) ? -rnd : rnd);
        return res;
    endfunction

    // Random bar: mixed volumes, with zero, one-sided, equal and tiny ones
    function automatic t_in_item make_bar();
        t_in_item bar;
        int       pick;
        pick = $urandom_range(0, 15);
        bar.bid_volume = $urandom;
        bar.ask_volume = $urandom;
        case (pick)
            0: bar = '0;
            1: bar.ask_volume = '0;
            2: bar.bid_volume = '0;
            3: bar.ask_volume = bar.bid_volume;
            4, 5, 6: begin
                bar.bid_volume = $urandom_range(0, 15);
                bar.ask_volume = $urandom_range(0, 15);
            end
            7, 8, 9, 10: ;
            11, 12: begin
                if ($urandom_range(0, 1))
                    bar.bid_volume = $urandom_range(0, 255);
                else
                    bar.ask_volume = $urandom_range(0, 255);
            end
            default: begin
                bar.bid_volume = bar.bid_volume >> $urandom_range(0, 31);
                bar.ask_volume = bar.ask_volume >> $urandom_range(0, 31);
            end
        endcase
        return bar;
    endfunction

    task automatic note_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Send one item, holding it until accepted
    task automatic send_bar(t_in_item bar);
        if (in_idle_en && $urandom_range(0, 2) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= bar;
        do @(posedge i_clk); while (o_in_stall);
        expected_ranks[exp_wr % EXP_DEPTH] = predict_rank(bar);
        exp_wr++;
        bars_sent++;
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
            send_bar(make_bar());
    endtask

    // Drop valid and wait for every pending result
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_LOOKBACK)
            lookback_reg = data[LEN_W-1:0];
        else if (index == CFG_ALPHA)
            alpha_reg = data[ALPHA_W-1:0];
    endtask

    // Reprogram both registers once the block is idle
    task automatic set_config(logic [CFG_DATA_W-1:0] len_data, logic [CFG_DATA_W-1:0] alpha);
        drain_results();
        write_reg(CFG_LOOKBACK, len_data);
        write_reg(CFG_ALPHA, alpha);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Reset values, field extremes, zero volume and the warm-up boundary
    task automatic test_directed_extremes();
        send_bar({32'd0, 32'd0});
        send_bar({32'd0, 32'd1});
        send_bar({32'd1, 32'd0});
        send_bar({32'd5, 32'd5});
        send_bar({32'hFFFF_FFFF, 32'hFFFF_FFFF});
        send_bar({32'hFFFF_FFFF, 32'd0});
        send_bar({32'd0, 32'hFFFF_FFFF});
        send_bar({32'd1, 32'd2});
        send_bar({32'd2, 32'd1});
        send_bar({32'hFFFF_FFFF, 32'hFFFF_FFFE});
        // zero volume just before the tenth value leaves the history alone
        send_bar({32'd0, 32'd0});
        send_bar({32'd3, 32'd1});
        send_bar({32'd1, 32'd3});
        send_bar({32'd0, 32'd7});
        send_bar({32'd9, 32'd0});
        send_bar({32'd100, 32'd101});
        send_bar({32'hFFFF_FFFF, 32'd1});
        send_bar({32'd1, 32'hFFFF_FFFF});
        send_bar({32'h8000_0000, 32'h7FFF_FFFF});
        send_bar({32'h5555_5555, 32'hAAAA_AAAA});
        send_bar({32'd0, 32'd0});
        send_bar({32'd7, 32'd7});
    endtask

    // Walk through register settings, extremes included
    task automatic test_config_sweep();
        // window of exactly ten values
        set_config(16'd10, 16'd3277);
        send_random(12);
        // one short of the minimum: warming up again
        set_config(16'd9, 16'd3277);
        send_random(12);
        // lookback of zero acts as one
        set_config(16'd0, 16'd3277);
        send_random(12);
        // no decay: flat weights
        set_config(16'd12, 16'd0);
        send_random(12);
        // grow the window so older ring entries count again
        set_config(16'd300, 16'd0);
        send_random(12);
        // widest window, steepest decay
        set_config(16'd16383, 16'hFFFF);
        send_random(12);
        // upper data bits beyond the lookback width are dropped
        set_config(16'hC028, 16'd32768);
        send_random(12);
        set_config(16'd50, 16'd66);
        send_random(12);
        set_config(16'd10000, 16'd1);
        send_random(12);
    endtask

    // Random traffic in chunks with random settings and idling
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] len_data;
        logic [CFG_DATA_W-1:0] alpha_data;
        for (int chunk = 0; chunk < 5; chunk++) begin
            if (chunk != 0) begin
                if ($urandom_range(0, 3) == 0)
                    len_data = 16'($urandom_range(0, 16383));
                else
                    len_data = 16'($urandom_range(10, 400));
                if ($urandom_range(0, 1))
                    alpha_data = 16'($urandom_range(66, 32768));
                else
                    alpha_data = 16'($urandom);
                set_config(len_data, alpha_data);
            end
            in_idle_en   = (chunk < 4) && ($urandom_range(0, 3) != 0);
            out_idle_en <= (chunk < 4) && ($urandom_range(0, 3) != 0);
            send_random(24);
        end
    endtask

    // Back-to-back items with no idling over wide and short windows
    task automatic test_wide_windows();
        in_idle_en   = 1'b0;
        out_idle_en <= 1'b0;
        set_config(16'd16383, 16'd0);
        send_random(2);
        set_config(16'd16383, 16'hFFFF);
        send_random(2);
        set_config(16'd40, 16'($urandom_range(66, 32768)));
        send_random(26);
    endtask

    // Receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (out_stall_left != 0) begin
            out_stall_left <= out_stall_left - 1;
            i_out_stall    <= 1'b1;
        end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
            out_stall_left <= $urandom_range(0, 9);
            i_out_stall    <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (exp_wr == exp_rd) begin
                note_mismatch("status of unexpected result", -1, int'(o_out_data.status));
            end else begin
                want = expected_ranks[exp_rd % EXP_DEPTH];
                exp_rd++;
                ranks_checked++;
                case (want.status)
                    ST_COMPUTED:  ranked_seen++;
                    ST_WARMING:   warming_seen++;
                    default:      no_volume_seen++;
                endcase
                if (o_out_data.level !== want.level)
                    note_mismatch("level", int'(want.level), int'(o_out_data.level));
                if (o_out_data.status !== want.status)
                    note_mismatch("status", int'(want.status), int'(o_out_data.status));
            end
        end
    end

    // Hard stop on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, exp_wr - exp_rd);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_extremes();
        test_config_sweep();
        test_random_traffic();
        test_wide_windows();
        drain_results();
        repeat (END_PAUSE) @(posedge i_clk);
        $display("Checked %0d results from %0d items: %0d ranked, %0d warming up, %0d zero volume",
                 ranks_checked, bars_sent, ranked_seen, warming_seen, no_volume_seen);
        $display("Register settings applied: %0d, with receiver stalls and input gaps",
                 settings_used);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
